// ----- sv/fahk_pkg.sv -----
// shared types, constants and tables for the five-axis kinematics block
package fahk_pkg;

    localparam int ZW = 34;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [19:0] angle_b;
        logic signed [19:0] angle_c;
    } t_pose_in;

    typedef struct packed {
        logic signed [23:0] joint_x;
        logic signed [23:0] joint_y;
        logic signed [23:0] joint_z;
        logic signed [19:0] joint_b;
        logic signed [19:0] joint_c;
    } t_pose_out;

    typedef enum logic [2:0] {
        REG_TCP_ENABLE = 3'd0,
        REG_TOOL_X     = 3'd1,
        REG_TOOL_Y     = 3'd2,
        REG_TOOL_Z     = 3'd3,
        REG_PIVOT      = 3'd4
    } t_reg_idx;

    // elaboration-time quotient by shift and subtract
    function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) at 2^61 by truncated alternating series
    function automatic logic [63:0] atan_inv(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] nn;
        logic [63:0] k;
        logic [63:0] t;
        logic [63:0] sum;
        p = cdiv(64'd1 << 61, n);
        nn = n * n;
        k = '0;
        sum = '0;
        while (p != 0) begin
            t = cdiv(p, 64'd2 * k + 64'd1);
            sum = k[0] ? sum - t : sum + t;
            p = cdiv(p, nn);
            k = k + 64'd1;
        end
        return sum;
    endfunction

    // pi/4 at 2^61 from machin's formula, and pi/180000 at 2^61
    localparam logic [63:0] QUARTER61 = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
    localparam logic [63:0] PI61 = QUARTER61 << 2;
    localparam logic [63:0] KR61 = cdiv(PI61 + 64'd90000, 64'd180000);

    // atan(2^-i) at 2^61, entry 0 is pi/4
    function automatic logic [63:0] atan61(input int i);
        if (i == 0) return QUARTER61;
        return atan_inv(64'd1 << i);
    endfunction

    function automatic logic signed [ZW-1:0] atan_f(input int i, input int f);
        logic [63:0] v;
        v = (atan61(i) + (64'd1 << (60 - f))) >> (61 - f);
        return ZW'(signed'(v));
    endfunction

    // inverse cordic gain (product of stage cosines), scaled to f bits; product over stages formed at 30 bits
    function automatic logic signed [ZW-1:0] gain_f(input int n, input int f);
        logic [63:0] k;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        k = 64'd1 << 30;
        for (int i = 0; i < 32; i++) begin
            if (i < n && 2 * i <= 30)
                k = cdiv(k << 30, (64'd1 << 30) + (64'd1 << (30 - 2 * i)));
        end
        v = k << 30;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (f < 30) res = (res + (64'd1 << (29 - f))) >> (30 - f);
        return ZW'(signed'(res));
    endfunction

endpackage

// ----- sv/five_axis_head_table_kinematics.sv -----
// five-axis head-table inverse kinematics top level
// throughput: one pose per cycle; the chain of cordic cells and the product
// stages behind it all advance together whenever the output is not stalled
// reset: synchronous active low; clears valid bits and config registers
module five_axis_head_table_kinematics #(
    parameter int CORDIC_STAGES = 24,
    parameter int FRAC_BITS     = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fahk_pkg::t_pose_in  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output fahk_pkg::t_pose_out o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    // cordic datapath width: fraction plus guard and sign
    localparam int W  = FRAC_BITS + 4;
    localparam int ZW = fahk_pkg::ZW;
    localparam int LAT = CORDIC_STAGES + 6;
    localparam logic signed [W-1:0] GAIN = W'(fahk_pkg::gain_f(CORDIC_STAGES, FRAC_BITS));
    localparam int RSH = 61 - FRAC_BITS;

    // whole pipeline moves when the output slot is free or empty
    logic adv;
    assign adv = !o_valid || !i_stall;
    assign o_stall = !adv;
    assign o_cfg_ready = 1'b1;

    // config registers
    logic r_tcp;
    logic signed [20:0] r_tox, r_toy, r_toz;
    logic signed [23:0] r_piv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcp <= 1'b0;
            r_tox <= '0;
            r_toy <= '0;
            r_toz <= '0;
            r_piv <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fahk_pkg::REG_TCP_ENABLE: r_tcp <= i_cfg_data[0];
                fahk_pkg::REG_TOOL_X:     r_tox <= i_cfg_data[20:0];
                fahk_pkg::REG_TOOL_Y:     r_toy <= i_cfg_data[20:0];
                fahk_pkg::REG_TOOL_Z:     r_toz <= i_cfg_data[20:0];
                fahk_pkg::REG_PIVOT:      r_piv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid shift line, one bit per stage
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LAT-2:0], i_valid};
    end
    assign o_valid = r_vld[LAT-1];

    // stage a: reduce angles mod 360000 (range is within +-524288, two steps)
    function automatic logic [18:0] wrap(input logic signed [19:0] a);
        logic signed [20:0] v;
        v = 21'(a);
        if (v < 0) v = v + 21'sd360000;
        if (v < 0) v = v + 21'sd360000;
        if (v >= 21'sd360000) v = v - 21'sd360000;
        return v[18:0];
    endfunction

    logic [18:0] r_mb, r_mc;
    fahk_pkg::t_pose_in r_pa;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mb <= wrap(i_data.angle_b);
            r_mc <= wrap(i_data.angle_c);
            r_pa <= i_data;
        end
    end

    // stage b: quadrant and remainder
    function automatic logic [1:0] quad(input logic [18:0] m);
        if (m >= 19'd270000) return 2'd3;
        else if (m >= 19'd180000) return 2'd2;
        else if (m >= 19'd90000) return 2'd1;
        return 2'd0;
    endfunction

    logic [1:0] qb, qc;
    assign qb = quad(r_mb);
    assign qc = quad(r_mc);
    logic [16:0] r_rb, r_rc;
    logic [3:0] r_qa;
    fahk_pkg::t_pose_in r_pb;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rb <= 17'(r_mb - 19'(qb) * 19'd90000);
            r_rc <= 17'(r_mc - 19'(qc) * 19'd90000);
            r_qa <= {qb, qc};
            r_pb <= r_pa;
        end
    end

    // stage c: remainder times pi/180000, rounded to cordic angle
    logic [80:0] pb_full, pc_full;
    assign pb_full = 81'(r_rb) * 81'(fahk_pkg::KR61);
    assign pc_full = 81'(r_rc) * 81'(fahk_pkg::KR61);
    logic signed [ZW-1:0] r_zb, r_zc;
    logic [3:0] r_qc;
    fahk_pkg::t_pose_in r_pc;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_zb <= ZW'((pb_full + (81'd1 << (RSH - 1))) >> RSH);
            r_zc <= ZW'((pc_full + (81'd1 << (RSH - 1))) >> RSH);
            r_qc <= r_qa;
            r_pc <= r_pb;
        end
    end

    // chain of cordic cells
    logic signed [W-1:0]  bx [CORDIC_STAGES+1];
    logic signed [W-1:0]  by [CORDIC_STAGES+1];
    logic signed [ZW-1:0] bz [CORDIC_STAGES+1];
    logic signed [W-1:0]  cx [CORDIC_STAGES+1];
    logic signed [W-1:0]  cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
    logic [3:0] qq [CORDIC_STAGES+1];
    fahk_pkg::t_pose_in pp [CORDIC_STAGES+1];
    assign bx[0] = GAIN;
    assign by[0] = '0;
    assign bz[0] = r_zb;
    assign cx[0] = GAIN;
    assign cy[0] = '0;
    assign cz[0] = r_zc;
    assign qq[0] = r_qc;
    assign pp[0] = r_pc;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        fahk_cell #(.IDX(g), .FRAC(FRAC_BITS), .W(W)) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_bx(bx[g]), .i_by(by[g]), .i_bz(bz[g]),
            .i_cx(cx[g]), .i_cy(cy[g]), .i_cz(cz[g]),
            .i_q(qq[g]), .i_pose(pp[g]),
            .o_bx(bx[g+1]), .o_by(by[g+1]), .o_bz(bz[g+1]),
            .o_cx(cx[g+1]), .o_cy(cy[g+1]), .o_cz(cz[g+1]),
            .o_q(qq[g+1]), .o_pose(pp[g+1])
        );
    end

    localparam int N = CORDIC_STAGES;

    // stage d: quadrant map, tool offset subtraction and pivot plus tool z sum
    logic signed [W-1:0] r_cb, r_sb, r_cc, r_sc;
    logic signed [24:0] r_px, r_py;
    logic signed [24:0] r_pl;
    fahk_pkg::t_pose_in r_pd;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (qq[N][3:2])
                2'd0: begin r_cb <= bx[N];  r_sb <= by[N];  end
                2'd1: begin r_cb <= -by[N]; r_sb <= bx[N];  end
                2'd2: begin r_cb <= -bx[N]; r_sb <= -by[N]; end
                default: begin r_cb <= by[N]; r_sb <= -bx[N]; end
            endcase
            case (qq[N][1:0])
                2'd0: begin r_cc <= cx[N];  r_sc <= cy[N];  end
                2'd1: begin r_cc <= -cy[N]; r_sc <= cx[N];  end
                2'd2: begin r_cc <= -cx[N]; r_sc <= -cy[N]; end
                default: begin r_cc <= cy[N]; r_sc <= -cx[N]; end
            endcase
            r_px <= 25'(pp[N].pos_x) - 25'(r_tox);
            r_py <= 25'(pp[N].pos_y) - 25'(r_toy);
            r_pl <= 25'(r_piv) + 25'(r_toz);
            r_pd <= pp[N];
        end
    end

    // stage e: products, one register after each multiply
    localparam int PW = 25 + W;
    logic signed [PW-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    fahk_pkg::t_pose_in r_pe;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m0 <= PW'(r_px) * PW'(r_cc);
            r_m1 <= PW'(r_py) * PW'(r_sc);
            r_m2 <= PW'(r_py) * PW'(r_cc);
            r_m3 <= PW'(r_px) * PW'(r_sc);
            r_m4 <= PW'(r_pl) * PW'(r_cb);
            r_m5 <= PW'(r_pl) * PW'(r_sb);
            r_pe <= r_pd;
        end
    end

    // stage f: sums, rounding, saturation, bypass
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam int RW = SW - FRAC_BITS + 1;
    logic signed [RW-1:0] xr, yr, xb, zb, jx, jy, jz;
    assign xr = RW'((SW'(r_m0) + SW'(r_m1) + HALF) >>> FRAC_BITS);
    assign yr = RW'((SW'(r_m2) - SW'(r_m3) + HALF) >>> FRAC_BITS);
    assign xb = RW'((SW'(r_m5) + HALF) >>> FRAC_BITS);
    assign zb = RW'((SW'(r_m4) + HALF) >>> FRAC_BITS) - RW'(r_piv);
    assign jx = xr - xb;
    assign jy = yr;
    assign jz = RW'(r_pe.pos_z) + zb;

    function automatic logic signed [23:0] sat(input logic signed [RW-1:0] v);
        if (v > RW'(24'sh7fffff)) return 24'sh7fffff;
        if (v < -RW'(25'sh800000)) return 24'sh800000;
        return v[23:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_tcp) begin
                o_data.joint_x <= sat(jx);
                o_data.joint_y <= sat(jy);
                o_data.joint_z <= sat(jz);
            end else begin
                o_data.joint_x <= r_pe.pos_x;
                o_data.joint_y <= r_pe.pos_y;
                o_data.joint_z <= r_pe.pos_z;
            end
            o_data.joint_b <= r_pe.angle_b;
            o_data.joint_c <= r_pe.angle_c;
        end
    end
endmodule

// ----- sv/fahk_cell.sv -----
// one cordic rotation cell: a register stage for two angle lanes plus payload
module fahk_cell #(
    parameter int IDX  = 0,
    parameter int FRAC = 24,
    parameter int W    = 34
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [W-1:0]             i_bx,
    input  logic signed [W-1:0]             i_by,
    input  logic signed [fahk_pkg::ZW-1:0]  i_bz,
    input  logic signed [W-1:0]             i_cx,
    input  logic signed [W-1:0]             i_cy,
    input  logic signed [fahk_pkg::ZW-1:0]  i_cz,
    input  logic [3:0]                      i_q,
    input  fahk_pkg::t_pose_in              i_pose,
    output logic signed [W-1:0]             o_bx,
    output logic signed [W-1:0]             o_by,
    output logic signed [fahk_pkg::ZW-1:0]  o_bz,
    output logic signed [W-1:0]             o_cx,
    output logic signed [W-1:0]             o_cy,
    output logic signed [fahk_pkg::ZW-1:0]  o_cz,
    output logic [3:0]                      o_q,
    output fahk_pkg::t_pose_in              o_pose
);
    localparam logic signed [fahk_pkg::ZW-1:0] ATAN = fahk_pkg::atan_f(IDX, FRAC);

    logic signed [W-1:0] r_bx, r_by, r_cx, r_cy;
    logic signed [fahk_pkg::ZW-1:0] r_bz, r_cz;
    logic [3:0] r_q;
    fahk_pkg::t_pose_in r_pose;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_bz[fahk_pkg::ZW-1]) begin
                r_bx <= i_bx - (i_by >>> IDX);
                r_by <= i_by + (i_bx >>> IDX);
                r_bz <= i_bz - ATAN;
            end else begin
                r_bx <= i_bx + (i_by >>> IDX);
                r_by <= i_by - (i_bx >>> IDX);
                r_bz <= i_bz + ATAN;
            end
            if (!i_cz[fahk_pkg::ZW-1]) begin
                r_cx <= i_cx - (i_cy >>> IDX);
                r_cy <= i_cy + (i_cx >>> IDX);
                r_cz <= i_cz - ATAN;
            end else begin
                r_cx <= i_cx + (i_cy >>> IDX);
                r_cy <= i_cy - (i_cx >>> IDX);
                r_cz <= i_cz + ATAN;
            end
            r_q    <= i_q;
            r_pose <= i_pose;
        end
    end

    assign o_bx = r_bx;
    assign o_by = r_by;
    assign o_bz = r_bz;
    assign o_cx = r_cx;
    assign o_cy = r_cy;
    assign o_cz = r_cz;
    assign o_q = r_q;
    assign o_pose = r_pose;
endmodule
